>>> rtl/tfsw_pkg.sv
// ----------------------------------------------------------------------------
// tfsw_pkg
// Shared types for the tent filter sample warp pipeline.
// ----------------------------------------------------------------------------
package tfsw_pkg;

    // side info that rides along with each word
    typedef struct packed {
        logic last;
        logic up_y;   // y took the upper branch (v >= 1/2)
        logic up_x;   // x took the upper branch (v >= 1/2)
    } t_tag;

endpackage

>>> rtl/tfsw_root_step.sv
// ----------------------------------------------------------------------------
// tfsw_root_step
// One digit of a restoring integer square root: brings down two radicand
// bits, tries the next root bit and keeps the partial remainder.
// ----------------------------------------------------------------------------
module tfsw_root_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic [FRAC_BITS+2:0] i_rem,
    input  logic [FRAC_BITS:0]   i_root,
    input  logic [1:0]           i_digit,
    output logic [FRAC_BITS+2:0] o_rem,
    output logic [FRAC_BITS:0]   o_root
);

    logic [FRAC_BITS+2:0] cand;
    logic [FRAC_BITS+2:0] trial;
    logic                 fits;

    always_comb begin
        cand  = {i_rem[FRAC_BITS:0], i_digit};
        trial = {i_root, 2'b01};
        fits  = (cand >= trial);
        o_rem  = fits ? (cand - trial) : cand;
        o_root = {i_root[FRAC_BITS-1:0], fits};
    end

endmodule

>>> rtl/tfsw_pipe_stage.sv
// ----------------------------------------------------------------------------
// tfsw_pipe_stage
// Registered square-root stage for both coordinates, with its own valid bit
// and backpressure so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module tfsw_pipe_stage #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    output logic                     o_rdy,
    input  logic [FRAC_BITS+2:0]     i_rem_x,
    input  logic [FRAC_BITS:0]       i_root_x,
    input  logic [2*FRAC_BITS+1:0]   i_rad_x,
    input  logic [FRAC_BITS+2:0]     i_rem_y,
    input  logic [FRAC_BITS:0]       i_root_y,
    input  logic [2*FRAC_BITS+1:0]   i_rad_y,
    input  tfsw_pkg::t_tag           i_tag,
    output logic                     o_vld,
    input  logic                     i_rdy,
    output logic [FRAC_BITS+2:0]     o_rem_x,
    output logic [FRAC_BITS:0]       o_root_x,
    output logic [2*FRAC_BITS+1:0]   o_rad_x,
    output logic [FRAC_BITS+2:0]     o_rem_y,
    output logic [FRAC_BITS:0]       o_root_y,
    output logic [2*FRAC_BITS+1:0]   o_rad_y,
    output tfsw_pkg::t_tag           o_tag
);

    logic                   r_vld;
    logic [FRAC_BITS+2:0]   r_rem_x,  r_rem_y;
    logic [FRAC_BITS:0]     r_root_x, r_root_y;
    logic [2*FRAC_BITS+1:0] r_rad_x,  r_rad_y;
    tfsw_pkg::t_tag         r_tag;

    logic [FRAC_BITS+2:0]   n_rem_x,  n_rem_y;
    logic [FRAC_BITS:0]     n_root_x, n_root_y;

    tfsw_root_step #(.FRAC_BITS(FRAC_BITS)) u_step_x (
        .i_rem   (i_rem_x),
        .i_root  (i_root_x),
        .i_digit (i_rad_x[2*FRAC_BITS+1:2*FRAC_BITS]),
        .o_rem   (n_rem_x),
        .o_root  (n_root_x)
    );

    tfsw_root_step #(.FRAC_BITS(FRAC_BITS)) u_step_y (
        .i_rem   (i_rem_y),
        .i_root  (i_root_y),
        .i_digit (i_rad_y[2*FRAC_BITS+1:2*FRAC_BITS]),
        .o_rem   (n_rem_y),
        .o_root  (n_root_y)
    );

    assign o_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_rem_x  <= n_rem_x;
            r_root_x <= n_root_x;
            r_rad_x  <= {i_rad_x[2*FRAC_BITS-1:0], 2'b00};
            r_rem_y  <= n_rem_y;
            r_root_y <= n_root_y;
            r_rad_y  <= {i_rad_y[2*FRAC_BITS-1:0], 2'b00};
            r_tag    <= i_tag;
        end
    end

    assign o_vld    = r_vld;
    assign o_rem_x  = r_rem_x;
    assign o_root_x = r_root_x;
    assign o_rad_x  = r_rad_x;
    assign o_rem_y  = r_rem_y;
    assign o_root_y = r_root_y;
    assign o_rad_y  = r_rad_y;
    assign o_tag    = r_tag;

endmodule

>>> rtl/tent_filter_sample_warp_core.sv
// ----------------------------------------------------------------------------
// tent_filter_sample_warp_core
// Warps uniform 2-D samples in [0,1)^2 to a tent distribution on [-1,1].
// ----------------------------------------------------------------------------
// Slave stream: one word per sample, tdata = {y, x} as unsigned
// Q0.FRAC_BITS, tuser = last flag. Master stream: tdata = {y, x} as signed
// Q1.FRAC_BITS, tuser = last flag copied through.
// Each coordinate: v < 1/2 gives sqrt(2v)-1, else 1-sqrt(2-2v), with the
// root floored.
// Stages: one argument stage, FRAC_BITS+1 square-root digit stages, one
// result stage. Throughput: one word per clock while i_m_tready is high;
// the digit-per-stage root pipeline sets the depth, not the rate.
// Reset clears all valid bits; the data registers are not reset.
// When the receiver stalls the output register holds its word, and each
// stage keeps accepting until it is full, so empty slots fill before
// o_s_tready drops. No word is lost or repeated.
// ----------------------------------------------------------------------------
module tent_filter_sample_warp_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // [F-1:0] x_in, [2F-1:F] y_in, upper bits zero padding
    input  logic [((2*FRAC_BITS+7)/8)*8-1:0]     i_s_tdata,
    // [0] last_in
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [F+1:0] x_out, [2F+3:F+2] y_out, upper bits zero padding
    output logic [((2*FRAC_BITS+11)/8)*8-1:0]    o_m_tdata,
    // [0] last_out
    output logic                                 o_m_tuser
);

    localparam int F      = FRAC_BITS;
    localparam int OUT_W  = ((2*FRAC_BITS+11)/8)*8;
    localparam int STEPS  = FRAC_BITS + 1;

    // ---------------- argument stage ----------------
    logic [F-1:0]     vx, vy;
    logic [F:0]       n_ax, n_ay;   // argument / 2, in Q0.F
    logic [2*F+1:0]   n_rad_x, n_rad_y;
    tfsw_pkg::t_tag   n_tag;

    logic             r_vld0;
    logic [2*F+1:0]   r_rad_x, r_rad_y;
    tfsw_pkg::t_tag   r_tag0;

    logic [STEPS:0]   w_vld;
    logic [STEPS:0]   w_rdy;

    always_comb begin
        vx = i_s_tdata[F-1:0];
        vy = i_s_tdata[2*F-1:F];
        n_ax = vx[F-1] ? (((F+1)'(1) << F) - {1'b0, vx}) : {1'b0, vx};
        n_ay = vy[F-1] ? (((F+1)'(1) << F) - {1'b0, vy}) : {1'b0, vy};
        n_rad_x = {n_ax, 1'b0, {F{1'b0}}};
        n_rad_y = {n_ay, 1'b0, {F{1'b0}}};
        n_tag.last = i_s_tuser;
        n_tag.up_y = vy[F-1];
        n_tag.up_x = vx[F-1];
    end

    assign o_s_tready = !r_vld0 || w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (o_s_tready) begin
            r_vld0 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_rad_x <= n_rad_x;
            r_rad_y <= n_rad_y;
            r_tag0  <= n_tag;
        end
    end

    // ---------------- square-root digit stages ----------------
    logic [F+2:0]     w_rem_x  [0:STEPS];
    logic [F:0]       w_root_x [0:STEPS];
    logic [2*F+1:0]   w_rad_x  [0:STEPS];
    logic [F+2:0]     w_rem_y  [0:STEPS];
    logic [F:0]       w_root_y [0:STEPS];
    logic [2*F+1:0]   w_rad_y  [0:STEPS];
    tfsw_pkg::t_tag   w_tag    [0:STEPS];

    assign w_vld[0]    = r_vld0;
    assign w_rem_x[0]  = '0;
    assign w_root_x[0] = '0;
    assign w_rad_x[0]  = r_rad_x;
    assign w_rem_y[0]  = '0;
    assign w_root_y[0] = '0;
    assign w_rad_y[0]  = r_rad_y;
    assign w_tag[0]    = r_tag0;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        tfsw_pipe_stage #(.FRAC_BITS(FRAC_BITS)) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_vld    (w_vld[k]),
            .o_rdy    (w_rdy[k]),
            .i_rem_x  (w_rem_x[k]),
            .i_root_x (w_root_x[k]),
            .i_rad_x  (w_rad_x[k]),
            .i_rem_y  (w_rem_y[k]),
            .i_root_y (w_root_y[k]),
            .i_rad_y  (w_rad_y[k]),
            .i_tag    (w_tag[k]),
            .o_vld    (w_vld[k+1]),
            .i_rdy    (w_rdy[k+1]),
            .o_rem_x  (w_rem_x[k+1]),
            .o_root_x (w_root_x[k+1]),
            .o_rad_x  (w_rad_x[k+1]),
            .o_rem_y  (w_rem_y[k+1]),
            .o_root_y (w_root_y[k+1]),
            .o_rad_y  (w_rad_y[k+1]),
            .o_tag    (w_tag[k+1])
        );
    end

    // ---------------- result stage ----------------
    logic [F+1:0]     one_fx;
    logic [F+1:0]     n_res_x, n_res_y;
    logic             r_out_vld;
    logic [F+1:0]     r_res_x, r_res_y;
    tfsw_pkg::t_tag   r_out_tag;

    always_comb begin
        one_fx  = (F+2)'(1) << F;
        n_res_x = w_tag[STEPS].up_x ? (one_fx - {1'b0, w_root_x[STEPS]})
                                    : ({1'b0, w_root_x[STEPS]} - one_fx);
        n_res_y = w_tag[STEPS].up_y ? (one_fx - {1'b0, w_root_y[STEPS]})
                                    : ({1'b0, w_root_y[STEPS]} - one_fx);
    end

    assign w_rdy[STEPS] = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_rdy[STEPS]) begin
            r_out_vld <= w_vld[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[STEPS] && w_vld[STEPS]) begin
            r_res_x   <= n_res_x;
            r_res_y   <= n_res_y;
            r_out_tag <= w_tag[STEPS];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_W'({r_res_y, r_res_x});
    assign o_m_tuser  = r_out_tag.last;

`ifndef SYNTHESIS
    // with the output slot free, every stage can advance
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> o_s_tready)
        else $error("input stalled with output register empty");

    // x on the lower branch always lands strictly below zero
    a_lower_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_tag.up_x) |-> r_res_x[F+1])
        else $error("lower-branch x result not negative");

    // y on the upper branch always lands in [0, 1]
    a_upper_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_tag.up_y) |-> (!r_res_y[F+1] && (r_res_y <= one_fx)))
        else $error("upper-branch y result out of range");

    // the output is never valid in the cycle after reset is asserted
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule
